### sv/cird_pkg.sv
`timescale 1ns / 1ps

package cird_pkg;

  // Sizing of the stores
  localparam int MAX_VERTICES = 32;
  localparam int MAX_CAPACITY = 128;
  localparam int LENGTH_WIDTH = 32;
  localparam int LOADS        = MAX_CAPACITY + 1;

  // Field widths fixed by the interface
  localparam int VTX_W      = 6;
  localparam int LOAD_W     = 8;
  localparam int COST_W     = 40;
  localparam int PRED_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Memory geometry
  localparam int DEM_DEPTH = MAX_VERTICES;
  localparam int DEM_AW    = $clog2(DEM_DEPTH);
  localparam int LEN_DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int LEN_AW    = $clog2(LEN_DEPTH);
  localparam int TBL_DEPTH = MAX_VERTICES * LOADS;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);

  typedef enum logic [1:0] {
    CMD_DEMAND = 2'd0,
    CMD_LENGTH = 2'd1,
    CMD_RUN    = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERTEX_COUNT     = 2'd0,
    CFG_VEHICLE_CAPACITY = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    KIND_QUERY = 1'b0,
    KIND_FILL  = 1'b1
  } result_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QOUT,
    ST_INIT0,
    ST_INITD,
    ST_DEM,
    ST_DEMW,
    ST_JCHK,
    ST_JACC,
    ST_WRB,
    ST_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_INF,
    WR_ZERO,
    WR_BEST
  } tbl_wr_t;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_QUERY,
    OUT_FILL
  } out_sel_t;

  typedef struct packed {
    cmd_code_t                       command;
    logic [VTX_W-1:0]                vertex;
    logic [VTX_W-1:0]                other_vertex;
    logic [LOAD_W-1:0]               load_value;
    logic signed [LENGTH_WIDTH-1:0]  edge_length;
  } in_item_t;

  typedef struct packed {
    result_kind_t              result_kind;
    logic signed [COST_W-1:0]  best_cost;
    logic                      finite;
    logic [PRED_W-1:0]         predecessor;
  } out_item_t;

  typedef struct packed {
    logic                      inf;
    logic signed [COST_W-1:0]  cost;
    logic [PRED_W-1:0]         pred;
  } tbl_word_t;

  localparam int TBL_W = $bits(tbl_word_t);

  // Controller to datapath commands
  typedef struct packed {
    logic               take;
    tbl_wr_t            tbl_wr;
    logic               rd_dem;
    logic               rd_src;
    logic               best_init;
    logic               best_acc;
    out_sel_t           out_sel;
    logic [VTX_W-1:0]   vtx_i;
    logic [VTX_W-1:0]   vtx_j;
    logic [LOAD_W-1:0]  load_c;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic               out_free;
    logic               dem_gt_c;
    logic [VTX_W-1:0]   n_sat;
    logic [LOAD_W-1:0]  cap_sat;
  } dp_status_t;

  // Table entry of vertex v at load c
  function automatic logic [TBL_AW-1:0] cell_addr(input logic [VTX_W-1:0] v,
                                                  input logic [LOAD_W-1:0] c);
    logic [VTX_W-1:0] vi;
    vi = v - VTX_W'(1);
    return TBL_AW'(vi) * TBL_AW'(LOADS) + TBL_AW'(c);
  endfunction

  // Length entry of ordered pair (v, o)
  function automatic logic [LEN_AW-1:0] len_addr(input logic [VTX_W-1:0] v,
                                                 input logic [VTX_W-1:0] o);
    logic [VTX_W-1:0] vi;
    logic [VTX_W-1:0] oi;
    vi = v - VTX_W'(1);
    oi = o - VTX_W'(1);
    return LEN_AW'(vi) * LEN_AW'(MAX_VERTICES) + LEN_AW'(oi);
  endfunction

  function automatic logic [DEM_AW-1:0] dem_addr(input logic [VTX_W-1:0] v);
    logic [VTX_W-1:0] vi;
    vi = v - VTX_W'(1);
    return DEM_AW'(vi);
  endfunction

  function automatic logic vtx_ok(input logic [VTX_W-1:0] v);
    return (v != '0) && (int'(v) <= MAX_VERTICES);
  endfunction

endpackage

### sv/cird_ram.sv
`timescale 1ns / 1ps

module cird_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port; read data holds without a read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/cird_dp.sv
`timescale 1ns / 1ps

module cird_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cird_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cird_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  cird_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output cird_pkg::out_item_t                 out_data,
  input  cird_pkg::dp_cmd_t                   cmd,
  output cird_pkg::dp_status_t                status
);

  logic [cird_pkg::VTX_W-1:0]  vertex_count_r, vertex_count_nxt;
  logic [cird_pkg::LOAD_W-1:0] vehicle_capacity_r, vehicle_capacity_nxt;

  logic                        dem_wr_en;
  logic [cird_pkg::LOAD_W-1:0] dem_rd;

  logic                                     len_wr_en;
  logic [cird_pkg::LEN_AW-1:0]              len_wr_addr;
  logic [cird_pkg::LEN_AW-1:0]              len_rd_addr;
  logic signed [cird_pkg::LENGTH_WIDTH-1:0] len_rd;

  logic                        query_take;
  logic                        tbl_wr_en;
  logic [cird_pkg::TBL_AW-1:0] tbl_wr_addr;
  cird_pkg::tbl_word_t         tbl_wr_data;
  logic                        tbl_rd_en;
  logic [cird_pkg::TBL_AW-1:0] tbl_rd_addr;
  cird_pkg::tbl_word_t         tbl_rd;

  logic qbad_r, qbad_nxt;

  logic signed [cird_pkg::COST_W:0]   sum_wide;
  logic signed [cird_pkg::COST_W-1:0] sum_sat;
  logic                               better;

  logic                               best_inf_r, best_inf_nxt;
  logic signed [cird_pkg::COST_W-1:0] best_cost_r, best_cost_nxt;
  logic [cird_pkg::PRED_W-1:0]        best_pred_r, best_pred_nxt;

  logic                out_valid_r, out_valid_nxt;
  cird_pkg::out_item_t out_data_r, out_data_nxt;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_comb begin
    vertex_count_nxt     = vertex_count_r;
    vehicle_capacity_nxt = vehicle_capacity_r;
    if (cfg_valid) begin
      case (cfg_index)
        cird_pkg::CFG_VERTEX_COUNT:
          vertex_count_nxt = cfg_data[cird_pkg::VTX_W-1:0];
        cird_pkg::CFG_VEHICLE_CAPACITY:
          vehicle_capacity_nxt = cfg_data[cird_pkg::LOAD_W-1:0];
        default:
          vertex_count_nxt = vertex_count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r     <= cird_pkg::VTX_W'(2);
      vehicle_capacity_r <= cird_pkg::LOAD_W'(1);
    end else begin
      vertex_count_r     <= vertex_count_nxt;
      vehicle_capacity_r <= vehicle_capacity_nxt;
    end
  end

  // Clamp the loop bounds to the store sizes
  assign status.n_sat = (int'(vertex_count_r) > cird_pkg::MAX_VERTICES) ?
                        cird_pkg::VTX_W'(cird_pkg::MAX_VERTICES) : vertex_count_r;
  assign status.cap_sat = (int'(vehicle_capacity_r) > cird_pkg::MAX_CAPACITY) ?
                          cird_pkg::LOAD_W'(cird_pkg::MAX_CAPACITY) : vehicle_capacity_r;

  // Demand store: written by demand loads, read once per table row
  assign dem_wr_en = cmd.take && (in_data.command == cird_pkg::CMD_DEMAND) &&
                     cird_pkg::vtx_ok(in_data.vertex);

  cird_ram #(
    .WIDTH (cird_pkg::LOAD_W),
    .DEPTH (cird_pkg::DEM_DEPTH)
  ) u_dem_ram (
    .clk     (clk),
    .wr_en   (dem_wr_en),
    .wr_addr (cird_pkg::dem_addr(in_data.vertex)),
    .wr_data (in_data.load_value),
    .rd_en   (cmd.rd_dem),
    .rd_addr (cird_pkg::dem_addr(cmd.vtx_i)),
    .rd_data (dem_rd)
  );

  assign status.dem_gt_c = dem_rd > cmd.load_c;

  // Length store: written by length loads, read once per candidate
  assign len_wr_en = cmd.take && (in_data.command == cird_pkg::CMD_LENGTH) &&
                     cird_pkg::vtx_ok(in_data.vertex) && cird_pkg::vtx_ok(in_data.other_vertex);
  assign len_wr_addr = cird_pkg::len_addr(in_data.vertex, in_data.other_vertex);
  assign len_rd_addr = cird_pkg::len_addr(cmd.vtx_i, cmd.vtx_j);

  cird_ram #(
    .WIDTH (cird_pkg::LENGTH_WIDTH),
    .DEPTH (cird_pkg::LEN_DEPTH)
  ) u_len_ram (
    .clk     (clk),
    .wr_en   (len_wr_en),
    .wr_addr (len_wr_addr),
    .wr_data (in_data.edge_length),
    .rd_en   (cmd.rd_src),
    .rd_addr (len_rd_addr),
    .rd_data (len_rd)
  );

  // Cost and predecessor table: one read port shared by queries and the fill
  assign query_take  = cmd.take && (in_data.command == cird_pkg::CMD_QUERY);
  assign tbl_rd_en   = query_take || cmd.rd_src;
  assign tbl_rd_addr = cmd.rd_src ?
                       cird_pkg::cell_addr(cmd.vtx_j, cmd.load_c - dem_rd) :
                       cird_pkg::cell_addr(in_data.vertex, in_data.load_value);
  assign tbl_wr_en   = cmd.tbl_wr != cird_pkg::WR_NONE;
  assign tbl_wr_addr = cird_pkg::cell_addr(cmd.vtx_i, cmd.load_c);

  always_comb begin
    tbl_wr_data.inf  = 1'b0;
    tbl_wr_data.cost = '0;
    tbl_wr_data.pred = '0;
    case (cmd.tbl_wr)
      cird_pkg::WR_INF: begin
        tbl_wr_data.inf = 1'b1;
      end
      cird_pkg::WR_BEST: begin
        tbl_wr_data.inf  = best_inf_r;
        tbl_wr_data.cost = best_cost_r;
        tbl_wr_data.pred = best_pred_r;
      end
      default: begin
        tbl_wr_data.inf = 1'b0;
      end
    endcase
  end

  cird_ram #(
    .WIDTH (cird_pkg::TBL_W),
    .DEPTH (cird_pkg::TBL_DEPTH)
  ) u_tbl_ram (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd)
  );

  // Hold whether the query addressed an entry outside the table
  assign qbad_nxt = query_take ?
                    !(cird_pkg::vtx_ok(in_data.vertex) &&
                      (int'(in_data.load_value) <= cird_pkg::MAX_CAPACITY)) : qbad_r;

  always_ff @(posedge clk) begin
    qbad_r <= qbad_nxt;
  end

  // Candidate cost: source entry plus edge length, saturated to the cost range
  always_comb begin
    sum_wide = {tbl_rd.cost[cird_pkg::COST_W-1], tbl_rd.cost} +
               {{(cird_pkg::COST_W + 1 - cird_pkg::LENGTH_WIDTH){len_rd[cird_pkg::LENGTH_WIDTH-1]}},
                len_rd};
    if (sum_wide[cird_pkg::COST_W] != sum_wide[cird_pkg::COST_W-1]) begin
      sum_sat = sum_wide[cird_pkg::COST_W] ? {1'b1, {(cird_pkg::COST_W-1){1'b0}}} :
                                             {1'b0, {(cird_pkg::COST_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[cird_pkg::COST_W-1:0];
    end
    better = !tbl_rd.inf && (best_inf_r || (sum_sat < best_cost_r));
  end

  // Running minimum over the candidates of one entry; ties keep the earlier one
  always_comb begin
    best_inf_nxt  = best_inf_r;
    best_cost_nxt = best_cost_r;
    best_pred_nxt = best_pred_r;
    if (cmd.best_init) begin
      best_inf_nxt  = 1'b1;
      best_cost_nxt = '0;
      best_pred_nxt = '0;
    end else if (cmd.best_acc && better) begin
      best_inf_nxt  = 1'b0;
      best_cost_nxt = sum_sat;
      best_pred_nxt = cird_pkg::PRED_W'(cmd.vtx_j);
    end
  end

  always_ff @(posedge clk) begin
    best_inf_r  <= best_inf_nxt;
    best_cost_r <= best_cost_nxt;
    best_pred_r <= best_pred_nxt;
  end

  // Output register: load a result beat, drop it when taken
  assign status.out_free = !out_valid_r || out_ready;

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (cmd.out_sel)
      cird_pkg::OUT_QUERY: begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.result_kind = cird_pkg::KIND_QUERY;
        out_data_nxt.finite      = !qbad_r && !tbl_rd.inf;
        out_data_nxt.best_cost   = (!qbad_r && !tbl_rd.inf) ? tbl_rd.cost : '0;
        out_data_nxt.predecessor = qbad_r ? '0 : tbl_rd.pred;
      end
      cird_pkg::OUT_FILL: begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.result_kind = cird_pkg::KIND_FILL;
        out_data_nxt.finite      = 1'b0;
        out_data_nxt.best_cost   = '0;
        out_data_nxt.predecessor = '0;
      end
      default: begin
        out_data_nxt = out_data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The table port never reads and writes in the same cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    !(tbl_wr_en && tbl_rd_en))
    else $error("table read and write in the same cycle");

  // A new result beat never overwrites one that is still pending
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_sel != cird_pkg::OUT_NONE) |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending beat");

  // A candidate is folded in only the cycle after its reads were issued
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.best_acc |-> $past(cmd.rd_src))
    else $error("candidate accumulated without read data");

  // A source read never underflows the load index
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_src |-> (dem_rd <= cmd.load_c))
    else $error("source load index underflow");

endmodule

### sv/cird_ctrl.sv
`timescale 1ns / 1ps

module cird_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cird_pkg::cmd_code_t   in_command,
  output cird_pkg::dp_cmd_t     cmd,
  input  cird_pkg::dp_status_t  status
);

  cird_pkg::ctrl_state_t state_r, state_nxt;

  logic [cird_pkg::VTX_W-1:0]  i_r, i_nxt;
  logic [cird_pkg::VTX_W-1:0]  j_r, j_nxt;
  logic [cird_pkg::LOAD_W-1:0] c_r, c_nxt;

  cird_pkg::ctrl_state_t       adv_state;
  logic [cird_pkg::VTX_W-1:0]  adv_i;
  logic [cird_pkg::LOAD_W-1:0] adv_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cird_pkg::ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      c_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      c_r     <= c_nxt;
    end
  end

  // Step to the next table row: vertex ascending, then load ascending
  always_comb begin
    adv_state = cird_pkg::ST_DEM;
    adv_i     = i_r + cird_pkg::VTX_W'(1);
    adv_c     = c_r;
    if (i_r >= status.n_sat) begin
      adv_i = cird_pkg::VTX_W'(2);
      if (c_r >= status.cap_sat) begin
        adv_state = cird_pkg::ST_DONE;
      end else begin
        adv_c = c_r + cird_pkg::LOAD_W'(1);
      end
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    c_nxt         = c_r;
    in_ready      = 1'b0;
    cmd.take      = 1'b0;
    cmd.tbl_wr    = cird_pkg::WR_NONE;
    cmd.rd_dem    = 1'b0;
    cmd.rd_src    = 1'b0;
    cmd.best_init = 1'b0;
    cmd.best_acc  = 1'b0;
    cmd.out_sel   = cird_pkg::OUT_NONE;
    cmd.vtx_i     = i_r;
    cmd.vtx_j     = j_r;
    cmd.load_c    = c_r;
    case (state_r)
      cird_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          case (in_command)
            cird_pkg::CMD_RUN: begin
              state_nxt = cird_pkg::ST_INIT0;
              i_nxt     = cird_pkg::VTX_W'(1);
              c_nxt     = '0;
            end
            cird_pkg::CMD_QUERY: begin
              state_nxt = cird_pkg::ST_QOUT;
            end
            default: begin
              state_nxt = cird_pkg::ST_IDLE;
            end
          endcase
        end
      end
      cird_pkg::ST_QOUT: begin
        if (status.out_free) begin
          cmd.out_sel = cird_pkg::OUT_QUERY;
          state_nxt   = cird_pkg::ST_IDLE;
        end
      end
      cird_pkg::ST_INIT0: begin
        // Mark load zero infinite for every vertex in use
        cmd.tbl_wr = cird_pkg::WR_INF;
        if (i_r >= status.n_sat) begin
          i_nxt     = cird_pkg::VTX_W'(1);
          c_nxt     = '0;
          state_nxt = cird_pkg::ST_INITD;
        end else begin
          i_nxt = i_r + cird_pkg::VTX_W'(1);
        end
      end
      cird_pkg::ST_INITD: begin
        // Depot row costs zero at every load
        cmd.tbl_wr = cird_pkg::WR_ZERO;
        if (c_r >= status.cap_sat) begin
          if ((status.cap_sat == '0) || (status.n_sat < cird_pkg::VTX_W'(2))) begin
            state_nxt = cird_pkg::ST_DONE;
          end else begin
            c_nxt     = cird_pkg::LOAD_W'(1);
            i_nxt     = cird_pkg::VTX_W'(2);
            state_nxt = cird_pkg::ST_DEM;
          end
        end else begin
          c_nxt = c_r + cird_pkg::LOAD_W'(1);
        end
      end
      cird_pkg::ST_DEM: begin
        cmd.rd_dem = 1'b1;
        state_nxt  = cird_pkg::ST_DEMW;
      end
      cird_pkg::ST_DEMW: begin
        if (status.dem_gt_c) begin
          cmd.tbl_wr = cird_pkg::WR_INF;
          state_nxt  = adv_state;
          i_nxt      = adv_i;
          c_nxt      = adv_c;
        end else begin
          cmd.best_init = 1'b1;
          j_nxt         = status.n_sat;
          state_nxt     = cird_pkg::ST_JCHK;
        end
      end
      cird_pkg::ST_JCHK: begin
        if (j_r == i_r) begin
          if (j_r <= cird_pkg::VTX_W'(1)) begin
            state_nxt = cird_pkg::ST_WRB;
          end else begin
            j_nxt = j_r - cird_pkg::VTX_W'(1);
          end
        end else begin
          cmd.rd_src = 1'b1;
          state_nxt  = cird_pkg::ST_JACC;
        end
      end
      cird_pkg::ST_JACC: begin
        cmd.best_acc = 1'b1;
        if (j_r <= cird_pkg::VTX_W'(1)) begin
          state_nxt = cird_pkg::ST_WRB;
        end else begin
          j_nxt     = j_r - cird_pkg::VTX_W'(1);
          state_nxt = cird_pkg::ST_JCHK;
        end
      end
      cird_pkg::ST_WRB: begin
        cmd.tbl_wr = cird_pkg::WR_BEST;
        state_nxt  = adv_state;
        i_nxt      = adv_i;
        c_nxt      = adv_c;
      end
      cird_pkg::ST_DONE: begin
        if (status.out_free) begin
          cmd.out_sel = cird_pkg::OUT_FILL;
          state_nxt   = cird_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cird_pkg::ST_IDLE;
      end
    endcase
  end

  // Candidate index stays within the vertices in use
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == cird_pkg::ST_JCHK) || (state_r == cird_pkg::ST_JACC)) |->
      ((j_r >= cird_pkg::VTX_W'(1)) && (j_r <= status.n_sat)))
    else $error("candidate vertex out of range");

  // Row and load counters stay inside the filled region
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == cird_pkg::ST_DEM) || (state_r == cird_pkg::ST_DEMW) ||
     (state_r == cird_pkg::ST_WRB)) |->
      ((i_r >= cird_pkg::VTX_W'(2)) && (i_r <= status.n_sat) &&
       (c_r >= cird_pkg::LOAD_W'(1)) && (c_r <= status.cap_sat)))
    else $error("row counters out of range");

  // An entry never takes itself as a candidate
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_src |-> (j_r != i_r))
    else $error("self candidate read");

endmodule

### sv/capacity_indexed_route_dp.sv
// Channel  Handshake              Beat
// cfg      cfg_valid/cfg_ready    cfg_index, cfg_data (register write)
// in       in_valid/in_ready      cird_pkg::in_item_t (load, run or query)
// out      out_valid/out_ready    cird_pkg::out_item_t (query answer or fill done)
//
// Loads may follow back to back; a query reads the table when its beat is taken and
// then loads the result beat. A run is paced by the single table read port: each
// candidate takes a table read and then a compare.
// Reset is synchronous; the stores are not cleared and hold nothing until written.
// in_ready drops during a run or query, which stalls at its end while a result waits.
`timescale 1ns / 1ps

module capacity_indexed_route_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cird_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cird_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  cird_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output cird_pkg::out_item_t             out_data
);

  cird_pkg::dp_cmd_t    cmd;
  cird_pkg::dp_status_t status;

  // Sequencer for loads, queries and the table fill
  cird_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_data.command),
    .cmd        (cmd),
    .status     (status)
  );

  // Stores, candidate arithmetic and output register
  cird_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

### verif/route_cost_monitor.sv
`timescale 1ns / 1ps

module route_cost_monitor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [cird_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cird_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  cird_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  cird_pkg::out_item_t             out_data,
  output int                              fail_count,
  output int                              pending_count
);
  import cird_pkg::*;

  localparam longint COST_TOP    = (longint'(1) <<< (COST_W - 1)) - 1;
  localparam longint COST_BOTTOM = -(longint'(1) <<< (COST_W - 1));

  // Shadow registers and stores of the route table
  logic [VTX_W-1:0]  vtx_count;
  logic [LOAD_W-1:0] veh_cap;
  logic [LOAD_W-1:0] demand_mem [1:MAX_VERTICES];
  longint            length_mem [1:MAX_VERTICES][1:MAX_VERTICES];
  longint            cost_mem   [1:MAX_VERTICES][0:MAX_CAPACITY];
  bit                inf_mem    [1:MAX_VERTICES][0:MAX_CAPACITY];
  logic [PRED_W-1:0] pred_mem   [1:MAX_VERTICES][0:MAX_CAPACITY];

  // Answers still owed by the block, oldest first
  out_item_t answer_q [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  // Fill the table in place: c ascending, i ascending, j descending
  function automatic void fill_route_table();
    int     n;
    int     cap;
    int     d;
    longint total;
    n   = (int'(vtx_count) > MAX_VERTICES) ? MAX_VERTICES : int'(vtx_count);
    cap = (int'(veh_cap) > MAX_CAPACITY) ? MAX_CAPACITY : int'(veh_cap);
    for (int i = 1; i <= n; i++) begin
      inf_mem[i][0]  = 1'b1;
      cost_mem[i][0] = 0;
      pred_mem[i][0] = '0;
    end
    for (int c = 0; c <= cap; c++) begin
      inf_mem[1][c]  = 1'b0;
      cost_mem[1][c] = 0;
      pred_mem[1][c] = '0;
    end
    for (int c = 1; c <= cap; c++) begin
      for (int i = 2; i <= n; i++) begin
        d = int'(demand_mem[i]);
        inf_mem[i][c]  = 1'b1;
        cost_mem[i][c] = 0;
        pred_mem[i][c] = '0;
        if (d <= c) begin
          for (int j = n; j >= 1; j--) begin
            if (j != i && !inf_mem[j][c-d]) begin
              total = cost_mem[j][c-d] + length_mem[i][j];
              if (total > COST_TOP) total = COST_TOP;
              if (total < COST_BOTTOM) total = COST_BOTTOM;
              // strict compare keeps the larger j on ties
              if (inf_mem[i][c] || total < cost_mem[i][c]) begin
                inf_mem[i][c]  = 1'b0;
                cost_mem[i][c] = total;
                pred_mem[i][c] = PRED_W'(j);
              end
            end
          end
        end
      end
    end
  endfunction

  // Apply one accepted input beat and queue the answer it owes
  function automatic void predict_beat(input in_item_t beat);
    out_item_t ans;
    bit        vok;
    bit        lok;
    int        v;
    int        o;
    int        lv;
    v   = int'(beat.vertex);
    o   = int'(beat.other_vertex);
    lv  = int'(beat.load_value);
    vok = (v >= 1) && (v <= MAX_VERTICES);
    lok = vok && (lv <= MAX_CAPACITY);
    ans = '0;
    case (beat.command)
      CMD_DEMAND: begin
        if (vok) demand_mem[v] = beat.load_value;
      end
      CMD_LENGTH: begin
        if (vok && o >= 1 && o <= MAX_VERTICES)
          length_mem[v][o] = longint'($signed(beat.edge_length));
      end
      CMD_RUN: begin
        fill_route_table();
        ans.result_kind = KIND_FILL;
        answer_q.push_back(ans);
      end
      CMD_QUERY: begin
        ans.result_kind = KIND_QUERY;
        if (lok) begin
          if (!inf_mem[v][lv]) begin
            ans.best_cost = COST_W'(cost_mem[v][lv]);
            ans.finite    = 1'b1;
          end
          ans.predecessor = pred_mem[v][lv];
        end
        answer_q.push_back(ans);
      end
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(input string field, input longint want,
                                        input longint got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endfunction

  // Compare one result beat with the oldest answer owed
  function automatic void check_answer(input out_item_t got);
    out_item_t want;
    if (answer_q.size() == 0) begin
      fail_count++;
      $display("%0t: result beat with nothing owed, got %p", $time, got);
      return;
    end
    want = answer_q.pop_front();
    if (got.result_kind !== want.result_kind)
      note_mismatch("result_kind", longint'(want.result_kind), longint'(got.result_kind));
    if (got.best_cost !== want.best_cost)
      note_mismatch("best_cost", longint'(want.best_cost), longint'(got.best_cost));
    if (got.finite !== want.finite)
      note_mismatch("finite", longint'(want.finite), longint'(got.finite));
    if (got.predecessor !== want.predecessor)
      note_mismatch("predecessor", longint'(want.predecessor), longint'(got.predecessor));
  endfunction

  // Watch all three channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      vtx_count = VTX_W'(2);
      veh_cap   = LOAD_W'(1);
      answer_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_VERTEX_COUNT:     vtx_count = cfg_data[VTX_W-1:0];
          CFG_VEHICLE_CAPACITY: veh_cap = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_answer(out_data);
      if (in_valid && in_ready) predict_beat(in_data);
    end
    pending_count = answer_q.size();
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cird_pkg::*;

  localparam int WATCHDOG_LIMIT = 1200000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 1500;
  // Register indexes past the two defined ones
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  int                    fail_count;
  int                    pending_count;

  // What the stimulus knows has been written, so no unwritten entry is read
  int cur_n   = 2;
  int cur_cap = 1;
  bit dem_known  [1:MAX_VERTICES];
  int dem_shadow [1:MAX_VERTICES];
  bit len_known  [1:MAX_VERTICES][1:MAX_VERTICES];
  bit cell_known [1:MAX_VERTICES][0:MAX_CAPACITY];
  int items_sent = 0;
  int burst_left = 0;
  int rx_left    = 0;
  int rx_mode    = 0;

  always #5 clk = ~clk;

  capacity_indexed_route_dp uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  route_cost_monitor chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Result side: runs of full rate, coin flips and hard stalls
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(1, 40);
    end
    rx_left--;
    case (rx_mode)
      0:       out_ready = 1'b1;
      1:       out_ready = $urandom_range(0, 1);
      default: out_ready = 1'b0;
    endcase
  end

  function automatic in_item_t make_beat(input cmd_code_t cmd, input int vtx, input int oth,
                                         input int lv, input logic [31:0] len);
    in_item_t b;
    b.command      = cmd;
    b.vertex       = VTX_W'(vtx);
    b.other_vertex = VTX_W'(oth);
    b.load_value   = LOAD_W'(lv);
    b.edge_length  = len;
    return b;
  endfunction

  function automatic logic [31:0] random_length();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom;
      4:       return -$urandom_range(0, 16384);
      default: return $urandom_range(0, 16384);
    endcase
  endfunction

  function automatic int pick_demand();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(0, 255);
      default: return $urandom_range(1, (cur_cap < 1) ? 1 : cur_cap);
    endcase
  endfunction

  function automatic int bad_vertex();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(MAX_VERTICES + 1, 63);
  endfunction

  // Drive one beat in bursts; hold it until accepted, then drop valid
  task automatic send_beat(input in_item_t beat);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    in_data  = beat;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Write a register once every owed result is in and the block has settled
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_index = idx;
    cfg_data  = data[7:0];
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == CFG_VERTEX_COUNT)
      cur_n = ((data & 63) > MAX_VERTICES) ? MAX_VERTICES : (data & 63);
    else if (idx == CFG_VEHICLE_CAPACITY)
      cur_cap = ((data & 255) > MAX_CAPACITY) ? MAX_CAPACITY : (data & 255);
  endtask

  task automatic load_demand(input int v, input int d);
    send_beat(make_beat(CMD_DEMAND, v, $urandom, d, $urandom));
    if (v >= 1 && v <= MAX_VERTICES) begin
      dem_known[v]  = 1'b1;
      dem_shadow[v] = d & 255;
    end
    items_sent++;
  endtask

  task automatic load_length(input int v, input int o, input logic [31:0] len);
    send_beat(make_beat(CMD_LENGTH, v, o, $urandom, len));
    if (v >= 1 && v <= MAX_VERTICES && o >= 1 && o <= MAX_VERTICES) len_known[v][o] = 1'b1;
    items_sent++;
  endtask

  task automatic query(input int v, input int lv);
    send_beat(make_beat(CMD_QUERY, v, $urandom, lv, $urandom));
    items_sent++;
  endtask

  task automatic send_bad_query();
    if ($urandom_range(0, 1))
      send_beat(make_beat(CMD_QUERY, bad_vertex(), $urandom, $urandom, $urandom));
    else
      send_beat(make_beat(CMD_QUERY, $urandom_range(1, MAX_VERTICES), $urandom,
                          $urandom_range(MAX_CAPACITY + 1, 255), $urandom));
  endtask

  // Loads at bad addresses and out-of-range queries
  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_beat(make_beat(CMD_DEMAND, bad_vertex(), $urandom, $urandom, $urandom));
      1: send_beat(make_beat(CMD_LENGTH, bad_vertex(), $urandom_range(0, 63), $urandom,
                             $urandom));
      2: send_beat(make_beat(CMD_LENGTH, $urandom_range(1, MAX_VERTICES), bad_vertex(),
                             $urandom, $urandom));
      default: send_bad_query();
    endcase
  endtask

  // Query a written entry, mostly inside the current fill
  task automatic random_query();
    int v;
    int lv;
    v  = $urandom_range(1, MAX_VERTICES);
    lv = $urandom_range(0, MAX_CAPACITY);
    if ($urandom_range(0, 4) != 0) begin
      v  = $urandom_range(1, (cur_n < 1) ? 1 : cur_n);
      lv = $urandom_range(0, cur_cap);
    end
    if (cell_known[v][lv]) query(v, lv);
    else send_bad_query();
  endtask

  // Load whatever the fill will read, then start it
  task automatic run_fill();
    bit stale;
    if (cur_cap >= 1) begin
      for (int i = 2; i <= cur_n; i++) begin
        if (!dem_known[i]) load_demand(i, $urandom_range(1, cur_cap));
        // zero demand reads higher rows at the same load from the last fill
        if (dem_shadow[i] == 0) begin
          stale = 1'b0;
          for (int j = i + 1; j <= cur_n; j++)
            for (int c = 1; c <= cur_cap; c++)
              if (!cell_known[j][c]) stale = 1'b1;
          if (stale) load_demand(i, 1);
        end
        for (int j = 1; j <= cur_n; j++)
          if (j != i && !len_known[i][j]) load_length(i, j, random_length());
      end
    end
    send_beat(make_beat(CMD_RUN, $urandom, $urandom, $urandom, $urandom));
    items_sent++;
    for (int i = 1; i <= cur_n; i++) cell_known[i][0] = 1'b1;
    for (int c = 0; c <= cur_cap; c++) cell_known[1][c] = 1'b1;
    for (int c = 1; c <= cur_cap; c++)
      for (int i = 2; i <= cur_n; i++) cell_known[i][c] = 1'b1;
  endtask

  task automatic random_round();
    int roll;
    int n_raw;
    int cap_raw;
    roll = $urandom_range(0, 9);
    if (roll < 7) begin
      n_raw   = (roll == 0) ? $urandom_range(0, 1) : $urandom_range(2, 7);
      cap_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(128, 255) : $urandom_range(0, 12);
      write_reg(CFG_VERTEX_COUNT, n_raw | ($urandom_range(0, 3) << 6));
      write_reg(CFG_VEHICLE_CAPACITY, cap_raw);
    end
    // fresh content, sparse on wide tables
    for (int i = 2; i <= cur_n; i++) begin
      if ($urandom_range(0, 2) != 0) load_demand(i, pick_demand());
      for (int j = 1; j <= cur_n; j++) begin
        if (j != i && $urandom_range(0, cur_n) < 3) load_length(i, j, random_length());
        if ($urandom_range(0, 15) == 0) send_noise();
      end
    end
    run_fill();
    repeat ($urandom_range(8, 30)) begin
      case ($urandom_range(0, 9))
        0: send_noise();
        1: load_demand($urandom_range(1, MAX_VERTICES), pick_demand());
        2: load_length($urandom_range(1, MAX_VERTICES), $urandom_range(1, MAX_VERTICES),
                       random_length());
        default: random_query();
      endcase
    end
    if ($urandom_range(0, 3) == 0) begin
      run_fill();
      repeat (10) random_query();
    end
  endtask

  // Watchdog: end the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed: two vertices, capacity one, largest length
    load_demand(2, 1);
    load_length(2, 1, 32'h7FFF_FFFF);
    send_beat(make_beat(CMD_DEMAND, 0, 0, 8'hFF, 32'hFFFF_FFFF));
    send_beat(make_beat(CMD_DEMAND, 63, 63, 8'hFF, 32'h0));
    send_beat(make_beat(CMD_LENGTH, 2, 0, 8'h00, 32'h1234_5678));
    send_beat(make_beat(CMD_LENGTH, 0, 1, 8'h00, 32'hFFFF_FFFF));
    send_beat(make_beat(CMD_LENGTH, 2, 63, 8'hFF, 32'h8000_0000));
    run_fill();
    query(1, 0);
    query(1, 1);
    query(2, 0);
    query(2, 1);
    // Out-of-range queries answer infinite
    query(0, 0);
    query(63, 255);
    query(1, MAX_CAPACITY + 1);
    query(MAX_VERTICES + 1, 1);
    // Most negative length, then a demand above the capacity
    load_length(2, 1, 32'h8000_0000);
    run_fill();
    query(2, 1);
    load_demand(2, 255);
    run_fill();
    query(2, 1);
    // Zero capacity, then vertex counts of zero and one
    write_reg(CFG_VEHICLE_CAPACITY, 0);
    run_fill();
    query(2, 0);
    write_reg(CFG_VERTEX_COUNT, 0);
    run_fill();
    write_reg(CFG_VERTEX_COUNT, 1);
    write_reg(CFG_SPARE_LO, $urandom);
    write_reg(CFG_SPARE_HI, $urandom);
    run_fill();
    query(1, 0);
    query(2, 1);

    // Zero demands loop through each other; repeated fills drive the cost to its floor
    write_reg(CFG_VERTEX_COUNT, 3);
    write_reg(CFG_VEHICLE_CAPACITY, 1);
    load_demand(2, 1);
    load_demand(3, 1);
    load_length(2, 1, 32'h7FFF_FFFF);
    load_length(3, 1, 32'h7FFF_FFFF);
    load_length(2, 3, 32'h8000_0000);
    load_length(3, 2, 32'h8000_0000);
    run_fill();
    load_demand(2, 0);
    load_demand(3, 0);
    repeat (140) begin
      run_fill();
      if ($urandom_range(0, 3) == 0) query($urandom_range(2, 3), 1);
    end
    query(2, 1);
    query(3, 1);
    query(3, 0);

    while (items_sent < 400) random_round();

    // Full vertex count at capacity one, upper data bits masked away
    write_reg(CFG_VERTEX_COUNT, 8'hE0);
    write_reg(CFG_VEHICLE_CAPACITY, 1);
    for (int i = 2; i <= MAX_VERTICES; i++) load_demand(i, pick_demand());
    run_fill();
    repeat (20) random_query();
    for (int i = 2; i <= MAX_VERTICES; i++)
      if ($urandom_range(0, 2) == 0) load_demand(i, $urandom_range(0, 1));
    run_fill();
    repeat (20) random_query();

    while (items_sent < RANDOM_ITEMS - 80) random_round();

    // Largest table: both registers saturate
    write_reg(CFG_VERTEX_COUNT, 8'hFF);
    write_reg(CFG_VEHICLE_CAPACITY, 8'hFF);
    for (int i = 2; i <= MAX_VERTICES; i++) load_demand(i, $urandom_range(1, 24));
    run_fill();
    query(MAX_VERTICES, MAX_CAPACITY);
    query(2, MAX_CAPACITY);
    repeat (40) random_query();

    // Drain and settle
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

### capacity_indexed_route_dp.f
sv/cird_pkg.sv
sv/cird_ram.sv
sv/cird_dp.sv
sv/cird_ctrl.sv
sv/capacity_indexed_route_dp.sv
verif/route_cost_monitor.sv
verif/tb_top.sv
